// ----- rtl/fct_pkg.sv -----
`timescale 1ns / 1ps

package fct_pkg;

   // fixed field widths of the stream and register ports
   localparam int KEY_W      = 32;
   localparam int INDEX_W    = 5;
   localparam int ENTRY_ID_W = 32;
   localparam int ENTRY_AD_W = 16;
   localparam int OUT_AD_W   = 16;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 24;

   // request kinds carried in tuser
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_WRITE  = 1'b1;

   // register indexes
   localparam logic CSR_OWN_ID      = 1'b0;
   localparam logic CSR_OWN_ADDRESS = 1'b1;

   // one finished lookup
   typedef struct packed {
      logic                key_in_successor_range;
      logic                preceding_is_self;
      logic [OUT_AD_W-1:0] preceding_address;
   } result_type;

endpackage

// ----- rtl/fct_mem.sv -----
`timescale 1ns / 1ps

module fct_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fct_scan.sv -----
`timescale 1ns / 1ps

module fct_scan #(
   parameter int ID_BITS   = 32,
   parameter int ADDR_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ID_BITS-1:0]         key,
   input  logic [ID_BITS-1:0]         own_id,
   input  logic [ADDR_BITS-1:0]       own_address,
   output logic                       rd_en,
   output logic [$clog2(ID_BITS)-1:0] rd_addr,
   input  logic [ID_BITS+ADDR_BITS-1:0] rd_data,
   output logic                       idle,
   output logic                       res_valid,
   input  logic                       res_ready,
   output fct_pkg::result_type        res
);

   localparam int AW = $clog2(ID_BITS);
   localparam logic [AW-1:0] LAST_IDX = AW'(ID_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [ID_BITS-1:0]     key_ff, key_in;
   logic                   hit_ff, hit_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   fct_pkg::result_type    res_ff, res_in;

   logic [ID_BITS-1:0]     cur_id;
   logic [ADDR_BITS-1:0]   cur_addr;
   logic                   in_open;
   logic                   in_succ;
   logic                   take;

   assign cur_id   = rd_data[ID_BITS-1:0];
   assign cur_addr = rd_data[ID_BITS +: ADDR_BITS];

   // circular interval tests against the entry read back this cycle
   always_comb begin
      if (own_id < key_ff) begin
         in_open = (own_id < cur_id) && (cur_id < key_ff);
      end else begin
         in_open = (own_id < cur_id) || (cur_id < key_ff);
      end
      if (own_id < cur_id) begin
         in_succ = (own_id < key_ff) && (key_ff <= cur_id);
      end else begin
         in_succ = (own_id < key_ff) || (key_ff <= cur_id);
      end
   end

   assign take = !hit_ff && in_open;

   // scan sequencer, one entry per cycle from the top index down
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      hit_in   = hit_ff;
      addr_in  = addr_ff;
      res_in   = res_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rd_en    = 1'b1;
               rd_addr  = LAST_IDX;
               idx_in   = LAST_IDX;
               key_in   = key;
               hit_in   = 1'b0;
               addr_in  = own_address;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (take) begin
               hit_in  = 1'b1;
               addr_in = cur_addr;
            end
            if (idx_ff == '0) begin
               res_in.preceding_address      = fct_pkg::OUT_AD_W'(take ? cur_addr : addr_ff);
               res_in.preceding_is_self      = !(hit_ff || take);
               res_in.key_in_successor_range = in_succ;
               state_in = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff - AW'(1);
               idx_in  = idx_ff - AW'(1);
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // scan payload
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      key_ff  <= key_in;
      hit_ff  <= hit_in;
      addr_ff <= addr_in;
      res_ff  <= res_in;
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

endmodule

// ----- rtl/chord_finger_table_lookup.sv -----
`timescale 1ns / 1ps

// channel | direction | transfer when             | payload
// req_    | in        | req_tvalid & req_tready   | tuser op, tdata key/index/id/address
// rsp_    | out       | rsp_tvalid & rsp_tready   | tdata address/self/successor flags
// csr_    | in        | csr_valid & csr_ready     | csr_index, csr_data
//
// a finger write goes straight into the table; a lookup holds the input side while
// the scan reads one finger entry a cycle from the table memory.
// the result then waits in an output register, so the next item can start while
// rsp_tready is low; the scan itself stalls only if that register is still full.
// reset clears control state and the node registers; finger entries are undefined until written.
// csr_ready is always high.
module chord_finger_table_lookup #(
   parameter int ID_BITS   = 32,
   parameter int ADDR_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] key, [36:32] finger_index, [68:37] entry_id, [84:69] entry_address
   input  logic [fct_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] operation
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] preceding_address, [16] preceding_is_self, [17] key_in_successor_range
   output logic [fct_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [fct_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int AW    = $clog2(ID_BITS);
   localparam int CMP_W = ((AW > fct_pkg::INDEX_W) ? AW : fct_pkg::INDEX_W) + 1;

   logic [fct_pkg::KEY_W-1:0]      req_key;
   logic [fct_pkg::INDEX_W-1:0]    req_index;
   logic [fct_pkg::ENTRY_ID_W-1:0] req_entry_id;
   logic [fct_pkg::ENTRY_AD_W-1:0] req_entry_address;
   logic                           req_xfer;
   logic                           lookup_start;
   logic                           index_ok;

   logic [ID_BITS-1:0]             own_id_ff;
   logic [ADDR_BITS-1:0]           own_address_ff;

   logic                           mem_wr_en;
   logic [AW-1:0]                  mem_wr_addr;
   logic [ID_BITS+ADDR_BITS-1:0]   mem_wr_data;
   logic                           mem_rd_en;
   logic [AW-1:0]                  mem_rd_addr;
   logic [ID_BITS+ADDR_BITS-1:0]   mem_rd_data;

   logic                           scan_idle;
   logic                           res_valid;
   logic                           res_take;
   fct_pkg::result_type            res;

   logic                           rsp_valid_ff;
   fct_pkg::result_type            rsp_res_ff;

   // request field unpacking
   assign req_key           = req_tdata[31:0];
   assign req_index         = req_tdata[36:32];
   assign req_entry_id      = req_tdata[68:37];
   assign req_entry_address = req_tdata[84:69];

   assign req_tready   = scan_idle;
   assign req_xfer     = req_tvalid && req_tready;
   assign lookup_start = req_xfer && (req_tuser == fct_pkg::OP_LOOKUP);

   // finger writes beyond the table are dropped
   assign index_ok    = CMP_W'(req_index) < CMP_W'(ID_BITS);
   assign mem_wr_en   = req_xfer && (req_tuser == fct_pkg::OP_WRITE) && index_ok;
   assign mem_wr_addr = AW'(req_index);
   assign mem_wr_data = {ADDR_BITS'(req_entry_address), ID_BITS'(req_entry_id)};

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff      <= '0;
         own_address_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fct_pkg::CSR_OWN_ID:      own_id_ff      <= ID_BITS'(csr_data);
            fct_pkg::CSR_OWN_ADDRESS: own_address_ff <= ADDR_BITS'(csr_data[15:0]);
            default: ;
         endcase
      end
   end

   fct_mem #(
      .DEPTH (ID_BITS),
      .WIDTH (ID_BITS + ADDR_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fct_scan #(
      .ID_BITS   (ID_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (lookup_start),
      .key         (ID_BITS'(req_key)),
      .own_id      (own_id_ff),
      .own_address (own_address_ff),
      .rd_en       (mem_rd_en),
      .rd_addr     (mem_rd_addr),
      .rd_data     (mem_rd_data),
      .idle        (scan_idle),
      .res_valid   (res_valid),
      .res_ready   (res_take),
      .res         (res)
   );

   // output register, refilled as it drains
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_res_ff.key_in_successor_range,
                        rsp_res_ff.preceding_is_self, rsp_res_ff.preceding_address};

   // a lookup closes the input side for the scan
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      lookup_start |=> !req_tready)
      else $error("input side open right after a lookup started");

   // a self answer carries the node's own address
   a_self_address: assert property (@(posedge clock) disable iff (reset)
      (res_take && res.preceding_is_self) |->
         (res.preceding_address == fct_pkg::OUT_AD_W'(own_address_ff)))
      else $error("self answer without own address");

   // a finished result that cannot move holds until taken
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_take) |=> (res_valid && $stable(res)))
      else $error("finished result lost before the output register took it");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int ID_BITS      = 32;
   localparam int ADDR_BITS    = 16;
   // cycles a lookup may still need once its result has left, plus margin
   localparam int SETTLE_CYCLES = ID_BITS + 8;
   // cycles with no transfer on any channel before the run is abandoned
   localparam int STALL_LIMIT   = 5000;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [fct_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [fct_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid;
   logic                           csr_ready;
   logic                           csr_index;
   logic [fct_pkg::CSR_DATA_W-1:0] csr_data;

   // shadow copy of the node registers and the finger table
   logic [ID_BITS-1:0]   node_id;
   logic [ADDR_BITS-1:0] node_addr;
   logic [ID_BITS-1:0]   finger_id_tab [ID_BITS];
   logic [ADDR_BITS-1:0] finger_addr_tab [ID_BITS];

   // routes predicted for accepted lookups, oldest first
   fct_pkg::result_type pending_routes [$];

   int unsigned req_idle_pct;
   int unsigned rsp_stall_pct;
   int unsigned fail_count;
   int unsigned quiet_cycles;

   chord_finger_table_lookup #(
      .ID_BITS   (ID_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // circular interval tests on unsigned identifiers
   function automatic bit in_open(input logic [ID_BITS-1:0] x, input logic [ID_BITS-1:0] a,
                                  input logic [ID_BITS-1:0] b);
      if (a < b) return (a < x) && (x < b);
      return (a < x) || (x < b);
   endfunction

   function automatic bit in_open_closed(input logic [ID_BITS-1:0] x,
                                         input logic [ID_BITS-1:0] a,
                                         input logic [ID_BITS-1:0] b);
      if (a < b) return (a < x) && (x <= b);
      return (a < x) || (x <= b);
   endfunction

   // closest preceding finger for a key, plus the successor test
   function automatic fct_pkg::result_type route_lookup(input logic [ID_BITS-1:0] target);
      fct_pkg::result_type r;
      r.preceding_address      = node_addr;
      r.preceding_is_self      = 1'b1;
      r.key_in_successor_range = in_open_closed(target, node_id, finger_id_tab[0]);
      for (int i = ID_BITS - 1; i >= 0; i--) begin
         if (r.preceding_is_self && in_open(finger_id_tab[i], node_id, target)) begin
            r.preceding_address = finger_addr_tab[i];
            r.preceding_is_self = 1'b0;
         end
      end
      return r;
   endfunction

   // identifier near where finger i of a well-formed table would point
   function automatic logic [ID_BITS-1:0] ring_point(input int i);
      return node_id + (32'd1 << i) + ID_BITS'($urandom_range(3));
   endfunction

   // one request transfer; the shadow state follows at acceptance
   task automatic send_item(input logic op, input logic [31:0] lookup_key,
                            input logic [4:0] idx, input logic [31:0] eid,
                            input logic [15:0] eaddr);
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, eaddr, eid, idx, lookup_key};
      do @(posedge clock); while (!req_tready);
      if (op == fct_pkg::OP_WRITE) begin
         finger_id_tab[idx]   = eid;
         finger_addr_tab[idx] = eaddr;
      end else begin
         pending_routes.insert(pending_routes.size(), route_lookup(lookup_key));
      end
   endtask

   task automatic do_lookup(input logic [31:0] lookup_key);
      send_item(fct_pkg::OP_LOOKUP, lookup_key, 5'($urandom), $urandom, 16'($urandom));
   endtask

   task automatic do_write(input logic [4:0] idx, input logic [31:0] eid,
                           input logic [15:0] eaddr);
      send_item(fct_pkg::OP_WRITE, $urandom, idx, eid, eaddr);
   endtask

   // sender holds off until every route is back and the scan has settled
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_routes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == fct_pkg::CSR_OWN_ID) node_id = value;
      else node_addr = value[ADDR_BITS-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_node(input logic [31:0] id_value, input logic [15:0] addr_value);
      wait_idle();
      write_csr(fct_pkg::CSR_OWN_ID, id_value);
      write_csr(fct_pkg::CSR_OWN_ADDRESS, {16'h0000, addr_value});
   endtask

   // every entry is written before any lookup reads the table
   task automatic test_fill_table();
      set_node(32'h1000_0000, 16'hABCD);
      for (int i = 0; i < ID_BITS; i++) do_write(5'(i), ring_point(i), 16'($urandom));
   endtask

   // keys on the edges of the intervals
   task automatic test_edge_keys();
      do_lookup(node_id);
      do_lookup(node_id + 1);
      do_lookup(node_id - 1);
      do_lookup(32'h0000_0000);
      do_lookup(32'hFFFF_FFFF);
      do_lookup(finger_id_tab[0]);
      do_lookup(finger_id_tab[0] + 1);
      do_lookup(finger_id_tab[ID_BITS-1]);
      do_lookup(finger_id_tab[ID_BITS-1] + 1);
   endtask

   // extreme entry values and fingers equal to the node itself
   task automatic test_edge_entries();
      do_write(5'd31, 32'hFFFF_FFFF, 16'hFFFF);
      do_write(5'd0, 32'h0000_0000, 16'h0000);
      do_lookup(32'h0000_0000);
      do_lookup(32'hFFFF_FFFF);
      do_write(5'd15, node_id, 16'h1234);
      do_lookup(node_id);
      do_write(5'd31, node_id + 1, 16'h5A5A);
      do_lookup(node_id + 2);
   endtask

   // node identifier at both ends of the ring
   task automatic test_config_extremes();
      set_node(32'hFFFF_FFFF, 16'hFFFF);
      do_lookup(32'h0000_0000);
      do_lookup(32'hFFFF_FFFF);
      do_lookup(32'hFFFF_FFFE);
      set_node(32'h0000_0000, 16'h0000);
      do_lookup(32'h0000_0000);
      do_lookup(32'h0000_0001);
      do_lookup(32'hFFFF_FFFF);
   endtask

   // mostly lookups, plus table updates, around interesting identifiers
   task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input logic [31:0] id_value, input logic [15:0] addr_value,
                                    input int n_items);
      logic [4:0]  idx;
      logic [31:0] value;
      set_node(id_value, addr_value);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < n_items; n++) begin
         // sender pauses once per phase until all routes are back
         if (n == n_items / 2) wait_idle();
         idx = 5'($urandom_range(ID_BITS - 1));
         if ($urandom_range(9) < 3) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: value = ring_point(idx);
               5, 6:          value = $urandom;
               7:             value = node_id;
               8:             value = finger_id_tab[$urandom_range(ID_BITS - 1)];
               default:       value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            endcase
            do_write(idx, value, 16'($urandom));
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3: value = $urandom;
               4:          value = node_id;
               5:          value = $urandom_range(1) ? node_id + 1 : node_id - 1;
               6:          value = finger_id_tab[idx];
               7:          value = finger_id_tab[idx] + ($urandom_range(1) ? 1 : -1);
               8:          value = finger_id_tab[0] + 32'($urandom_range(1));
               default:    value = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            endcase
            do_lookup(value);
         end
      end
   endtask

   // receiver stalls
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   // route checker
   always @(posedge clock) begin
      fct_pkg::result_type want;
      fct_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = fct_pkg::result_type'(rsp_tdata[17:0]);
         if (pending_routes.size() == 0) begin
            $display("%0t unexpected route: expected none, actual %h", $time, got);
            fail_count++;
         end else begin
            want = pending_routes.pop_front();
            if (got.preceding_address !== want.preceding_address) begin
               $display("%0t preceding_address: expected %h, actual %h", $time,
                        want.preceding_address, got.preceding_address);
               fail_count++;
            end
            if (got.preceding_is_self !== want.preceding_is_self) begin
               $display("%0t preceding_is_self: expected %b, actual %b", $time,
                        want.preceding_is_self, got.preceding_is_self);
               fail_count++;
            end
            if (got.key_in_successor_range !== want.key_in_successor_range) begin
               $display("%0t key_in_successor_range: expected %b, actual %b", $time,
                        want.key_in_successor_range, got.key_in_successor_range);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
         $display("** chord_finger_table_lookup: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = fct_pkg::OP_LOOKUP;
      rsp_tready    = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = fct_pkg::CSR_OWN_ID;
      csr_data      = '0;
      node_id       = '0;
      node_addr     = '0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      fail_count    = 0;
      quiet_cycles  = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_fill_table();
      test_edge_keys();
      test_edge_entries();
      test_config_extremes();
      test_random_phase(0, 0, $urandom, 16'($urandom), 280);
      test_random_phase(87, 0, 32'hFFFF_FFFF, 16'h0000, 280);
      test_random_phase(0, 87, 32'h0000_0000, 16'hFFFF, 280);
      test_random_phase(22, 22, $urandom, 16'($urandom), 280);

      rsp_stall_pct = 0;
      wait_idle();
      if (fail_count == 0) begin
         $display("** chord_finger_table_lookup: PASSED **");
      end else begin
         $display("** chord_finger_table_lookup: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/fct_pkg.sv
rtl/fct_mem.sv
rtl/fct_scan.sv
rtl/chord_finger_table_lookup.sv
test/tb_top.sv
